// File: rtl/scb_pkg.sv
// ----------------------------------------------------------------------------
// scb_pkg
// Shared types and constants for the sprite column texture blender.
// ----------------------------------------------------------------------------
package scb_pkg;

   localparam int TEX_DEPTH   = 65536;
   localparam int PAL_DEPTH   = 8192;
   localparam int FRAME_DEPTH = 65536;
   localparam int MAX_COUNT   = 1024;
   localparam int TRANS_DEPTH = 65536;

   localparam logic [7:0] SKIP_TEXEL = 8'd255;

   localparam logic [2:0] ACT_WR_TEX   = 3'd0;
   localparam logic [2:0] ACT_WR_PAL   = 3'd1;
   localparam logic [2:0] ACT_WR_TRANS = 3'd2;
   localparam logic [2:0] ACT_WR_FRAME = 3'd3;
   localparam logic [2:0] ACT_RD_FRAME = 3'd4;
   localparam logic [2:0] ACT_DRAW     = 3'd5;

   localparam logic [1:0] MODE_OPAQUE = 2'd0;
   localparam logic [1:0] MODE_MASKED = 2'd1;
   localparam logic [1:0] MODE_TRANS  = 2'd2;

   localparam logic [2:0] REG_PITCH   = 3'd0;
   localparam logic [2:0] REG_TEX_H   = 3'd1;
   localparam logic [2:0] REG_U_STEP  = 3'd2;
   localparam logic [2:0] REG_V_STEP  = 3'd3;
   localparam logic [2:0] REG_SHADE   = 3'd4;
   localparam logic [2:0] REG_REVERSE = 3'd5;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] addr;
      logic [7:0]  data;
      logic [31:0] u_start;
      logic [31:0] v_start;
      logic [10:0] count;
      logic [15:0] tex_base;
      logic [15:0] dest_addr;
      logic [1:0]  draw_mode;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       done_res;
   } rsp_type;

   typedef struct packed {
      logic [12:0] pitch;
      logic [12:0] tex_height;
      logic [31:0] u_step;
      logic [31:0] v_step;
      logic [12:0] shade_offset;
      logic        trans_reverse;
   } cfg_type;

endpackage

// File: rtl/scb_ram.sv
// ----------------------------------------------------------------------------
// scb_ram
// Byte-wide synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module scb_ram #(
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [7:0]               rd_data
);

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: rtl/scb_cfg.sv
// ----------------------------------------------------------------------------
// scb_cfg
// Configuration register file.
// ----------------------------------------------------------------------------
module scb_cfg (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data,
   output scb_pkg::cfg_type  cfg
);

   scb_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pitch         <= 13'd256;
         cfg_ff.tex_height    <= 13'd64;
         cfg_ff.u_step        <= 32'd0;
         cfg_ff.v_step        <= 32'd65536;
         cfg_ff.shade_offset  <= 13'd0;
         cfg_ff.trans_reverse <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            scb_pkg::REG_PITCH:   cfg_ff.pitch         <= csr_data[12:0];
            scb_pkg::REG_TEX_H:   cfg_ff.tex_height    <= csr_data[12:0];
            scb_pkg::REG_U_STEP:  cfg_ff.u_step        <= csr_data;
            scb_pkg::REG_V_STEP:  cfg_ff.v_step        <= csr_data;
            scb_pkg::REG_SHADE:   cfg_ff.shade_offset  <= csr_data[12:0];
            scb_pkg::REG_REVERSE: cfg_ff.trans_reverse <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/sprite_column_texture_blender.sv
// ----------------------------------------------------------------------------
// sprite_column_texture_blender
// Draws textured columns into a frame store through palette and blend table.
// ----------------------------------------------------------------------------
// Sequence: store writes, unknown actions and empty draws go straight to the
//   result, a frame read waits on the registered frame store read, and a draw
//   walks each pixel's texel, palette and frame, blend reads and the frame write
//   through the registered-read RAMs one after another.
// Throughput: one item at a time; next item accepted the cycle after the result
//   transfer. Reset: synchronous, clears control; registers reload, stores stay.
// ----------------------------------------------------------------------------
module sprite_column_texture_blender #(
   parameter int TEX_DEPTH   = scb_pkg::TEX_DEPTH,
   parameter int PAL_DEPTH   = scb_pkg::PAL_DEPTH,
   parameter int FRAME_DEPTH = scb_pkg::FRAME_DEPTH,
   parameter int MAX_COUNT   = scb_pkg::MAX_COUNT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  scb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output scb_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_data
);

   localparam int TW = $clog2(TEX_DEPTH);
   localparam int PW = $clog2(PAL_DEPTH);
   localparam int FW = $clog2(FRAME_DEPTH);
   localparam int CW = $clog2(MAX_COUNT + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_RDF, ST_TEX, ST_PAL, ST_DST, ST_BLEND, ST_WRITE, ST_RESP
   } state_type;

   scb_pkg::cfg_type cfg;
   scb_cfg u_cfg (
      .clock, .reset, .csr_wr_en, .csr_index, .csr_data, .cfg
   );

   state_type   state_ff;
   logic [31:0] u_ff, v_ff;
   logic [CW-1:0] n_ff;
   logic [15:0] base_ff;
   logic [FW-1:0] dest_ff;
   logic [1:0]  mode_ff;
   logic [7:0]  texel_ff, color_ff;
   scb_pkg::rsp_type rsp_ff;
   logic [FW-1:0] rd_addr_ff;

   logic          tex_we, pal_we, trn_we, frm_we;
   logic [TW-1:0] tex_wa, tex_ra;
   logic [PW-1:0] pal_wa, pal_ra;
   logic [15:0]   trn_wa, trn_ra;
   logic [FW-1:0] frm_wa, frm_ra;
   logic [7:0]    tex_wd, pal_wd, trn_wd, frm_wd;
   logic [7:0]    tex_q, pal_q, trn_q, frm_q;

   logic          accept;
   logic [CW-1:0] cnt_sat, n_in;
   logic [28:0]   tmul;
   logic [TW-1:0] tex_addr;
   logic [PW-1:0] pal_idx;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_data  = rsp_ff;

   always_comb begin
      if (int'(req_data.count) > MAX_COUNT) cnt_sat = CW'(MAX_COUNT);
      else                                  cnt_sat = CW'(req_data.count);
      n_in = (cnt_sat >= CW'(2)) ? cnt_sat - CW'(1) : '0;
      if (req_data.draw_mode == 2'd3) n_in = '0;
      tmul = 29'(u_ff[31:16]) * 29'(cfg.tex_height);
      tex_addr = TW'(32'(base_ff) + 32'(tmul) + 32'(v_ff[31:16]));
      if (mode_ff == scb_pkg::MODE_MASKED)
         pal_idx = PW'(14'(texel_ff) + 14'(cfg.shade_offset));
      else
         pal_idx = PW'(texel_ff);
   end

   always_comb begin
      tex_we = accept && req_data.action == scb_pkg::ACT_WR_TEX;
      pal_we = accept && req_data.action == scb_pkg::ACT_WR_PAL;
      trn_we = accept && req_data.action == scb_pkg::ACT_WR_TRANS;
      tex_wa = TW'(req_data.addr);
      pal_wa = PW'(req_data.addr);
      trn_wa = req_data.addr;
      tex_wd = req_data.data;
      pal_wd = req_data.data;
      trn_wd = req_data.data;
      tex_ra = tex_addr;
      pal_ra = pal_idx;
      if (cfg.trans_reverse) trn_ra = {pal_q, frm_q};
      else                   trn_ra = {frm_q, pal_q};
      frm_ra = (state_ff == ST_RDF) ? rd_addr_ff : dest_ff;
      frm_we = 1'b0;
      frm_wa = dest_ff;
      frm_wd = pal_q;
      if (accept && req_data.action == scb_pkg::ACT_WR_FRAME) begin
         frm_we = 1'b1;
         frm_wa = FW'(req_data.addr);
         frm_wd = req_data.data;
      end else if (state_ff == ST_WRITE) begin
         frm_we = (mode_ff == scb_pkg::MODE_OPAQUE) || texel_ff != scb_pkg::SKIP_TEXEL;
         frm_wd = (mode_ff == scb_pkg::MODE_TRANS) ? trn_q : color_ff;
      end
   end

   scb_ram #(.DEPTH(TEX_DEPTH)) u_tex (.clock, .wr_en(tex_we), .wr_addr(tex_wa),
      .wr_data(tex_wd), .rd_addr(tex_ra), .rd_data(tex_q));
   scb_ram #(.DEPTH(PAL_DEPTH)) u_pal (.clock, .wr_en(pal_we), .wr_addr(pal_wa),
      .wr_data(pal_wd), .rd_addr(pal_ra), .rd_data(pal_q));
   scb_ram #(.DEPTH(scb_pkg::TRANS_DEPTH)) u_trn (.clock, .wr_en(trn_we),
      .wr_addr(trn_wa), .wr_data(trn_wd), .rd_addr(trn_ra), .rd_data(trn_q));
   scb_ram #(.DEPTH(FRAME_DEPTH)) u_frm (.clock, .wr_en(frm_we), .wr_addr(frm_wa),
      .wr_data(frm_wd), .rd_addr(frm_ra), .rd_data(frm_q));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: if (accept) begin
               u_ff       <= req_data.u_start;
               v_ff       <= req_data.v_start;
               base_ff    <= req_data.tex_base;
               dest_ff    <= FW'(req_data.dest_addr);
               mode_ff    <= req_data.draw_mode;
               n_ff       <= (req_data.action == scb_pkg::ACT_DRAW) ? n_in : '0;
               rd_addr_ff <= FW'(req_data.addr);
               rsp_ff     <= '{read_data: 8'd0,
                               done_res: req_data.action <= scb_pkg::ACT_DRAW};
               if (req_data.action == scb_pkg::ACT_RD_FRAME) state_ff <= ST_RDF;
               else if (req_data.action == scb_pkg::ACT_DRAW && n_in != '0)
                  state_ff <= ST_TEX;
               else state_ff <= ST_RESP;
            end
            ST_RDF: state_ff <= ST_BLEND;
            ST_TEX: state_ff <= ST_PAL;
            ST_PAL: begin
               texel_ff <= tex_q;
               state_ff <= ST_DST;
            end
            ST_DST: state_ff <= ST_BLEND;
            ST_BLEND: begin
               if (n_ff == '0) begin
                  rsp_ff.read_data <= frm_q;
                  state_ff <= ST_RESP;
               end else begin
                  color_ff <= pal_q;
                  state_ff <= ST_WRITE;
               end
            end
            ST_WRITE: begin
               u_ff    <= u_ff + cfg.u_step;
               v_ff    <= v_ff + cfg.v_step;
               dest_ff <= FW'(32'(dest_ff) + 32'(cfg.pitch));
               n_ff    <= n_ff - CW'(1);
               state_ff <= (n_ff == CW'(1)) ? ST_RESP : ST_TEX;
            end
            ST_RESP: if (rsp_ready) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped");
   a_write_n: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |-> n_ff != '0) else $error("pixel with no count");
`endif

endmodule

// File: dv/scb_column_checker.sv
// ----------------------------------------------------------------------------
// scb_column_checker
// Watches the request, response and register ports of the column blender,
// keeps its own copy of the four byte stores and the register set, works out
// the response of every accepted request and compares it with the response
// the block delivers, in order.
// ----------------------------------------------------------------------------
module scb_column_checker
   import scb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          errors
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [7:0] tex_mem   [TEX_DEPTH];
   logic [7:0] pal_mem   [PAL_DEPTH];
   logic [7:0] trans_mem [TRANS_DEPTH];
   logic [7:0] frame_mem [FRAME_DEPTH];

   cfg_type cfg;
   rsp_type rsp_due[$];

   task automatic render_item(input req_type it, output rsp_type r);
      logic [10:0] cnt;
      int          n;
      logic [31:0] u;
      logic [31:0] v;
      logic [31:0] prod;
      logic [15:0] d;
      logic [15:0] ta;
      logic [7:0]  tx;
      logic [7:0]  col;
      logic [7:0]  dst;
      logic [12:0] pi;
      r.read_data = 8'd0;
      r.done_res  = 1'b1;
      case (it.action)
         ACT_WR_TEX:   tex_mem[it.addr] = it.data;
         ACT_WR_PAL:   pal_mem[it.addr[12:0]] = it.data;
         ACT_WR_TRANS: trans_mem[it.addr] = it.data;
         ACT_WR_FRAME: frame_mem[it.addr] = it.data;
         ACT_RD_FRAME: r.read_data = frame_mem[it.addr];
         ACT_DRAW: begin
            cnt = (it.count > MAX_COUNT) ? 11'(MAX_COUNT) : it.count;
            n = (cnt >= 2) ? int'(cnt) - 1 : 0;
            if (it.draw_mode > MODE_TRANS) n = 0;
            u = it.u_start;
            v = it.v_start;
            d = it.dest_addr;
            for (int i = 0; i < n; i++) begin
               prod = 32'(u[31:16]) * 32'(cfg.tex_height);
               ta = it.tex_base + prod[15:0] + v[31:16];
               tx = tex_mem[ta];
               if (it.draw_mode == MODE_OPAQUE) begin
                  frame_mem[d] = pal_mem[13'(tx)];
               end else if (it.draw_mode == MODE_MASKED) begin
                  pi = 13'(tx) + cfg.shade_offset;
                  if (tx != SKIP_TEXEL) frame_mem[d] = pal_mem[pi];
               end else if (tx != SKIP_TEXEL) begin
                  col = pal_mem[13'(tx)];
                  dst = frame_mem[d];
                  frame_mem[d] = cfg.trans_reverse ? trans_mem[{col, dst}]
                                                   : trans_mem[{dst, col}];
               end
               u = u + cfg.u_step;
               v = v + cfg.v_step;
               d = d + 16'(cfg.pitch);
            end
         end
         default: r.done_res = 1'b0;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type exp_r;
      rsp_type got;
      int      bad;
      bad = 0;
      if (reset) begin
         cfg.pitch         <= 13'd256;
         cfg.tex_height    <= 13'd64;
         cfg.u_step        <= 32'd0;
         cfg.v_step        <= 32'd65536;
         cfg.shade_offset  <= 13'd0;
         cfg.trans_reverse <= 1'b0;
         rsp_due.delete();
         errors <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_PITCH:   cfg.pitch         <= csr_data[12:0];
               REG_TEX_H:   cfg.tex_height    <= csr_data[12:0];
               REG_U_STEP:  cfg.u_step        <= csr_data;
               REG_V_STEP:  cfg.v_step        <= csr_data;
               REG_SHADE:   cfg.shade_offset  <= csr_data[12:0];
               REG_REVERSE: cfg.trans_reverse <= csr_data[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (rsp_due.size() == 0) begin
               $display("%0t: response with nothing due, actual %h", $time, got);
               bad = bad + 1;
            end else begin
               exp_r = rsp_due.pop_front();
               if (got.read_data !== exp_r.read_data) begin
                  $display("%0t: read_data expected %h actual %h",
                           $time, exp_r.read_data, got.read_data);
                  bad = bad + 1;
               end
               if (got.done_res !== exp_r.done_res) begin
                  $display("%0t: done_res expected %b actual %b",
                           $time, exp_r.done_res, got.done_res);
                  bad = bad + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            render_item(req_data, exp_r);
            rsp_due.push_back(exp_r);
         end
         errors <= errors + bad;
      end
   end

endmodule

// File: dv/tb_sprite_column_texture_blender.sv
// ----------------------------------------------------------------------------
// tb_sprite_column_texture_blender
// Loads the palette and blend table entries the draws can reach, then runs
// directed and random store writes, frame reads and column draws over a series
// of register settings, with random stalls on both channels. Every store entry
// is written before any access can read it. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_sprite_column_texture_blender;
   import scb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT = 600000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   int          errors;

   int  cycles = 0;
   int  sent = 0;
   int  taken = 0;
   bit  quiet = 1'b1;
   bit  tex_ok   [TEX_DEPTH];
   bit  frame_ok [FRAME_DEPTH];
   bit  pal_ok   [PAL_DEPTH];
   logic [12:0] cur_pitch = 13'd256;
   logic [12:0] cur_tex_h = 13'd64;
   logic [31:0] cur_u_step = 32'd0;
   logic [31:0] cur_v_step = 32'd65536;
   logic [12:0] cur_shade = 13'd0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   sprite_column_texture_blender u_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_wr_en, .csr_index, .csr_data
   );

   scb_column_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_wr_en, .csr_index, .csr_data,
      .errors
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && rsp_ready) taken <= taken + 1;
      if (cycles > LIMIT) begin
         $display("tb_sprite_column_texture_blender: done, errors");
         $finish;
      end
   end

   always @(negedge clock) rsp_ready = quiet || ($urandom_range(99) >= 32);

   task automatic push_req(input req_type it);
      while (!quiet && $urandom_range(99) < 32) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = it;
      do @(posedge clock); while (!req_ready);
      sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (taken != sent) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_data  = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         REG_PITCH:  cur_pitch  = val[12:0];
         REG_TEX_H:  cur_tex_h  = val[12:0];
         REG_U_STEP: cur_u_step = val;
         REG_V_STEP: cur_v_step = val;
         REG_SHADE:  cur_shade  = val[12:0];
         default: ;
      endcase
   endtask

   function automatic req_type rnd_req();
      req_type it;
      it.action    = 3'($urandom_range(7));
      it.addr      = 16'($urandom);
      it.data      = 8'($urandom);
      it.u_start   = $urandom;
      it.v_start   = $urandom;
      it.count     = 11'($urandom);
      it.tex_base  = 16'($urandom);
      it.dest_addr = 16'($urandom);
      it.draw_mode = 2'($urandom_range(3));
      return it;
   endfunction

   // frame, palette and blend bytes stay within this set
   function automatic logic [7:0] pick_color(input int k);
      case (k)
         0: return 8'h00;
         1: return 8'h01;
         2: return 8'h5A;
         3: return 8'hA5;
         4: return 8'h7F;
         5: return 8'h80;
         6: return 8'hFE;
         default: return 8'hFF;
      endcase
   endfunction

   // texels stay within this set; the last one is the skip texel
   function automatic logic [7:0] pick_texel(input int k);
      case (k)
         0: return 8'h00;
         1: return 8'h01;
         2: return 8'h02;
         3: return 8'h7F;
         4: return 8'h80;
         5: return 8'hFD;
         6: return 8'hFE;
         default: return SKIP_TEXEL;
      endcase
   endfunction

   function automatic logic [7:0] rnd_color();
      return pick_color($urandom_range(7));
   endfunction

   function automatic logic [7:0] rnd_texel();
      return ($urandom_range(3) == 0) ? SKIP_TEXEL : pick_texel($urandom_range(6));
   endfunction

   task automatic write_byte(input logic [2:0] act, input logic [15:0] a,
                             input logic [7:0] val);
      req_type it;
      it = rnd_req();
      it.action = act;
      it.addr   = a;
      it.data   = val;
      push_req(it);
      if (act == ACT_WR_TEX) tex_ok[a] = 1'b1;
      if (act == ACT_WR_FRAME) frame_ok[a] = 1'b1;
      if (act == ACT_WR_PAL) pal_ok[a[12:0]] = 1'b1;
   endtask

   // write any texture, palette or frame entry the request would read before it is set
   task automatic load_missing(input req_type it);
      logic [10:0] cnt;
      int          n;
      logic [31:0] u;
      logic [31:0] v;
      logic [31:0] prod;
      logic [15:0] d;
      logic [15:0] ta;
      logic [12:0] pi;
      if (it.action == ACT_RD_FRAME && !frame_ok[it.addr])
         write_byte(ACT_WR_FRAME, it.addr, rnd_color());
      if (it.action != ACT_DRAW) return;
      cnt = (it.count > MAX_COUNT) ? 11'(MAX_COUNT) : it.count;
      n = (cnt >= 2) ? int'(cnt) - 1 : 0;
      if (it.draw_mode > MODE_TRANS) n = 0;
      if (it.draw_mode == MODE_MASKED && n > 0) begin
         for (int k = 0; k < 7; k++) begin
            pi = 13'(pick_texel(k)) + cur_shade;
            if (!pal_ok[pi]) write_byte(ACT_WR_PAL, 16'(pi), rnd_color());
         end
      end
      u = it.u_start;
      v = it.v_start;
      d = it.dest_addr;
      for (int i = 0; i < n; i++) begin
         prod = 32'(u[31:16]) * 32'(cur_tex_h);
         ta = it.tex_base + prod[15:0] + v[31:16];
         if (!tex_ok[ta]) write_byte(ACT_WR_TEX, ta, rnd_texel());
         if (it.draw_mode == MODE_TRANS && !frame_ok[d])
            write_byte(ACT_WR_FRAME, d, rnd_color());
         u = u + cur_u_step;
         v = v + cur_v_step;
         d = d + 16'(cur_pitch);
      end
   endtask

   task automatic issue(input req_type it);
      logic [15:0] d;
      load_missing(it);
      push_req(it);
      if (it.action == ACT_WR_TEX) tex_ok[it.addr] = 1'b1;
      if (it.action == ACT_WR_FRAME) frame_ok[it.addr] = 1'b1;
      if (it.action == ACT_WR_PAL) pal_ok[it.addr[12:0]] = 1'b1;
      if (it.action == ACT_DRAW && it.draw_mode == MODE_OPAQUE && it.count >= 2) begin
         d = it.dest_addr;
         for (int i = 0; i < int'((it.count > MAX_COUNT) ? MAX_COUNT : it.count) - 1; i++)
         begin
            frame_ok[d] = 1'b1;
            d = d + 16'(cur_pitch);
         end
      end
   endtask

   task automatic draw_req(input logic [1:0] mode, input logic [10:0] cnt);
      req_type it;
      it = rnd_req();
      it.action    = ACT_DRAW;
      it.draw_mode = mode;
      it.count     = cnt;
      issue(it);
   endtask

   function automatic logic [31:0] rnd_step();
      if ($urandom_range(7) == 0) return $urandom;
      return 32'($signed($urandom_range(32768)) - 16384);
   endfunction

   initial begin
      req_type it;
      int      pick;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      for (int k = 0; k < 8; k++) write_byte(ACT_WR_PAL, 16'(pick_texel(k)), rnd_color());
      for (int a = 0; a < 8; a++) begin
         for (int b = 0; b < 8; b++)
            write_byte(ACT_WR_TRANS, {pick_color(a), pick_color(b)}, rnd_color());
      end
      quiet = 1'b0;

      write_byte(ACT_WR_TEX, 16'd0, 8'd0);
      write_byte(ACT_WR_TEX, 16'hFFFF, 8'hFF);
      write_byte(ACT_WR_PAL, 16'hFFFF, 8'hFF);
      write_byte(ACT_WR_PAL, 16'd0, 8'd0);
      write_byte(ACT_WR_TRANS, 16'hFFFF, 8'd0);
      write_byte(ACT_WR_FRAME, 16'd0, 8'hFF);
      write_byte(ACT_WR_FRAME, 16'hFFFF, 8'd0);
      it = rnd_req(); it.action = ACT_RD_FRAME; it.addr = 16'hFFFF; issue(it);
      it = rnd_req(); it.action = ACT_RD_FRAME; it.addr = 16'd0; issue(it);
      draw_req(MODE_OPAQUE, 11'd0);
      draw_req(MODE_MASKED, 11'd1);
      draw_req(MODE_TRANS, 11'd2);
      draw_req(2'd3, 11'd50);
      it = rnd_req(); it.action = 3'd6; issue(it);
      it = rnd_req(); it.action = 3'd7; issue(it);
      it = rnd_req(); it.action = ACT_DRAW; it.u_start = '1; it.v_start = '1;
      it.tex_base = '1; it.dest_addr = '1; it.count = 11'd9; it.draw_mode = MODE_TRANS;
      issue(it);
      wait_drained();

      set_reg(REG_PITCH, 32'd4096); set_reg(REG_V_STEP, 32'h0000_0400);
      it = rnd_req(); it.action = ACT_DRAW;
      it.count = 11'd2047; it.draw_mode = MODE_OPAQUE; issue(it);
      it.count = 11'd1025; it.draw_mode = MODE_MASKED; issue(it);
      it.count = 11'd1024; it.draw_mode = MODE_TRANS; issue(it);
      wait_drained();

      for (int p = 0; p < 12; p++) begin
         case (p)
            0: begin
               set_reg(REG_PITCH, 32'd1);    set_reg(REG_TEX_H, 32'd1);
               set_reg(REG_U_STEP, 32'h8000_0000); set_reg(REG_V_STEP, 32'h7FFF_FFFF);
               set_reg(REG_SHADE, 32'd0);    set_reg(REG_REVERSE, 32'd1);
            end
            1: begin
               set_reg(REG_PITCH, 32'd4096); set_reg(REG_TEX_H, 32'd4096);
               set_reg(REG_U_STEP, 32'h7FFF_FFFF); set_reg(REG_V_STEP, 32'h8000_0000);
               set_reg(REG_SHADE, 32'd8191); set_reg(REG_REVERSE, 32'd0);
            end
            2: begin
               set_reg(REG_PITCH, 32'd0);    set_reg(REG_TEX_H, 32'd0);
               set_reg(REG_U_STEP, 32'd0);   set_reg(REG_V_STEP, 32'd0);
               set_reg(REG_SHADE, 32'd1);    set_reg(REG_REVERSE, 32'd1);
            end
            3: begin
               set_reg(REG_PITCH, 32'hFFFF_FFFF); set_reg(REG_TEX_H, 32'hFFFF_FFFF);
               set_reg(REG_U_STEP, 32'hFFFF_FFFF); set_reg(REG_V_STEP, 32'd1);
               set_reg(REG_SHADE, 32'hFFFF_FFFF); set_reg(REG_REVERSE, 32'hFFFF_FFFE);
            end
            default: begin
               set_reg(REG_PITCH, $urandom);  set_reg(REG_TEX_H, $urandom);
               set_reg(REG_U_STEP, rnd_step()); set_reg(REG_V_STEP, rnd_step());
               set_reg(REG_SHADE, $urandom);  set_reg(REG_REVERSE, $urandom);
            end
         endcase
         quiet = (p == 6 || p == 7);
         for (int k = 0; k < 40; k++) begin
            it = rnd_req();
            pick = $urandom_range(99);
            if (pick < 45) begin
               it.action = ACT_DRAW;
               pick = $urandom_range(99);
               if (pick < 85) it.count = 11'($urandom_range(12));
               else it.count = 11'($urandom_range(48));
               it.draw_mode = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
            end else if (pick < 60) begin
               it.action = ACT_RD_FRAME;
            end else if (pick < 97) begin
               it.action = 3'($urandom_range(3));
               it.data = (it.action == ACT_WR_TEX) ? rnd_texel() : rnd_color();
            end else begin
               it.action = 3'($urandom_range(7, 6));
            end
            issue(it);
         end
         wait_drained();
      end

      quiet = 1'b1;
      wait_drained();
      if (errors == 0) begin
         $display("tb_sprite_column_texture_blender: done, clean");
      end else begin
         $display("tb_sprite_column_texture_blender: done, errors");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/scb_pkg.sv
rtl/scb_ram.sv
rtl/scb_cfg.sv
rtl/sprite_column_texture_blender.sv
dv/scb_column_checker.sv
dv/tb_sprite_column_texture_blender.sv
